### rtl/core/assert_macros.svh
// assertion macros shared by the decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define SPD_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("spd assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define SPD_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spd assertion failed");

`endif

### rtl/core/spd_pkg.sv
// types, constants and helpers of the sparse packet decoder
package spd_pkg;

   localparam int DELTA_BITS  = 45;
   localparam int VALUE_BITS  = 64;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] HDR_GROUP         = 3'd0;
   localparam logic [2:0] HDR_LITERAL_FIRST = 3'd5;
   localparam logic [2:0] LAST_VALUE_BYTE   = 3'd7;

   typedef enum logic [1:0] {
      KIND_BYTE   = 2'd0,
      KIND_TABLE  = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_HEAD  = 2'd0,
      PH_CODE  = 2'd1,
      PH_VALUE = 2'd2,
      PH_DELTA = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      OP_ENTRY = 2'd0,
      OP_GROUP = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [DELTA_BITS-1:0]   delta;
      logic [VALUE_BITS-1:0]   value;
   } cmd_type;

   // number of delta bytes that follow the payload of each header
   function automatic logic [2:0] delta_len(input logic [2:0] hdr);
      logic [2:0] len;
      case (hdr)
         3'd2:    len = 3'd1;
         3'd3:    len = 3'd3;
         3'd4:    len = 3'd5;
         3'd6:    len = 3'd2;
         3'd7:    len = 3'd5;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

endpackage

### rtl/core/sparse_packet_decoder.sv
// top level of the sparse packet decoder
// The decoder takes one item per clock cycle: stream bytes, value table writes
// and new-stream commands. The front end parses each byte in the cycle it is
// accepted and reads the 256-entry value table on a code byte; each finished
// packet becomes a command in a two-entry queue, and the back end applies it to
// the row and column and loads the result register. Input stalls only when the
// result register, the queue and the front end's command register are all full.
module sparse_packet_decoder
   import spd_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256,
   parameter int COORD_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_stream_byte,
   input  logic [7:0]  req_table_index,
   input  logic [63:0] req_table_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_row,
   output logic [31:0] rsp_col,
   output logic [63:0] rsp_value_bits,
   output logic        rsp_group_end
);

   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_cmd;

   spd_front #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_stream_byte (req_stream_byte),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .push_valid      (push_valid),
      .push_cmd        (push_cmd),
      .push_ready      (push_ready)
   );

   spd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   spd_back #(
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (pop_valid),
      .in_cmd         (pop_cmd),
      .in_ready       (pop_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_row        (rsp_row),
      .rsp_col        (rsp_col),
      .rsp_value_bits (rsp_value_bits),
      .rsp_group_end  (rsp_group_end)
   );

endmodule

### rtl/core/spd_front.sv
// front end: accepts items, owns the value table and parses packets into commands
module spd_front
   import spd_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_stream_byte,
   input  logic [7:0]  req_table_index,
   input  logic [63:0] req_table_value,
   output logic        push_valid,
   output cmd_type     push_cmd,
   input  logic        push_ready
);

   localparam int IDX_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   logic [VALUE_BITS-1:0] table_mem [TABLE_ENTRIES];
   logic [VALUE_BITS-1:0] rd_ff;
   logic                  rd_oor_ff;

   phase_type             phase_ff, phase_in;
   logic [2:0]            hdr_ff, hdr_in;
   logic [2:0]            cnt_ff, cnt_in;
   logic [DELTA_BITS-1:0] delta_ff, delta_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  vsel_ff, vsel_in;
   logic                  cmd_valid_ff, cmd_valid_in;
   cmd_type               cmd_ff, cmd_in;
   logic                  cmd_tbl_ff, cmd_tbl_in;

   logic       accept;
   logic       code_rd;
   logic       wr_en;
   logic [2:0] dlen;
   kind_type   kind;

   assign kind      = kind_type'(req_kind);
   assign req_ready = !cmd_valid_ff || push_ready;
   assign accept    = req_valid && req_ready;
   assign code_rd   = accept && (kind == KIND_BYTE) && (phase_ff == PH_CODE);
   assign wr_en     = accept && (kind == KIND_TABLE)
                      && ({1'b0, req_table_index} < 9'(TABLE_ENTRIES));
   assign dlen      = delta_len(hdr_ff);

   // value table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[req_table_index[IDX_BITS-1:0]] <= req_table_value;
      end
      if (code_rd) begin
         rd_ff     <= table_mem[req_stream_byte[IDX_BITS-1:0]];
         rd_oor_ff <= ({1'b0, req_stream_byte} >= 9'(TABLE_ENTRIES));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEAD;
         hdr_ff       <= '0;
         cnt_ff       <= '0;
         delta_ff     <= '0;
         value_ff     <= '0;
         vsel_ff      <= 1'b0;
         cmd_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hdr_ff       <= hdr_in;
         cnt_ff       <= cnt_in;
         delta_ff     <= delta_in;
         value_ff     <= value_in;
         vsel_ff      <= vsel_in;
         cmd_valid_ff <= cmd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      cmd_tbl_ff <= cmd_tbl_in;
   end

   always_comb begin
      phase_in     = phase_ff;
      hdr_in       = hdr_ff;
      cnt_in       = cnt_ff;
      delta_in     = delta_ff;
      value_in     = value_ff;
      vsel_in      = vsel_ff;
      cmd_valid_in = cmd_valid_ff && !push_ready;
      cmd_in       = cmd_ff;
      cmd_tbl_in   = cmd_tbl_ff;
      if (accept) begin
         case (kind)
            KIND_CLEAR: begin
               phase_in     = PH_HEAD;
               hdr_in       = '0;
               cnt_in       = '0;
               delta_in     = '0;
               value_in     = '0;
               vsel_in      = 1'b0;
               cmd_valid_in = 1'b1;
               cmd_in.op    = OP_CLEAR;
               cmd_in.delta = '0;
               cmd_in.value = '0;
               cmd_tbl_in   = 1'b0;
            end
            KIND_BYTE: begin
               case (phase_ff)
                  PH_HEAD: begin
                     hdr_in   = req_stream_byte[2:0];
                     delta_in = DELTA_BITS'(req_stream_byte[7:3]);
                     value_in = '0;
                     cnt_in   = '0;
                     vsel_in  = 1'b0;
                     if (req_stream_byte[2:0] == HDR_GROUP) begin
                        cmd_valid_in = 1'b1;
                        cmd_in.op    = OP_GROUP;
                        cmd_in.delta = '0;
                        cmd_in.value = '0;
                        cmd_tbl_in   = 1'b0;
                     end else if (req_stream_byte[2:0] < HDR_LITERAL_FIRST) begin
                        phase_in = PH_CODE;
                     end else begin
                        phase_in = PH_VALUE;
                     end
                  end
                  PH_CODE: begin
                     vsel_in = 1'b1;
                     cnt_in  = '0;
                     if (dlen == 3'd0) begin
                        phase_in     = PH_HEAD;
                        cmd_valid_in = 1'b1;
                        cmd_in.op    = OP_ENTRY;
                        cmd_in.delta = delta_ff;
                        cmd_in.value = '0;
                        cmd_tbl_in   = 1'b1;
                     end else begin
                        phase_in = PH_DELTA;
                     end
                  end
                  PH_VALUE: begin
                     value_in = value_ff | (VALUE_BITS'(req_stream_byte) << {cnt_ff, 3'b000});
                     cnt_in   = cnt_ff + 3'd1;
                     if (cnt_ff == LAST_VALUE_BYTE) begin
                        cnt_in = '0;
                        if (dlen == 3'd0) begin
                           phase_in     = PH_HEAD;
                           cmd_valid_in = 1'b1;
                           cmd_in.op    = OP_ENTRY;
                           cmd_in.delta = delta_ff;
                           cmd_in.value = value_in;
                           cmd_tbl_in   = 1'b0;
                        end else begin
                           phase_in = PH_DELTA;
                        end
                     end
                  end
                  PH_DELTA: begin
                     delta_in = delta_ff
                                | (DELTA_BITS'(req_stream_byte) << (6'd5 + {cnt_ff, 3'b000}));
                     cnt_in   = cnt_ff + 3'd1;
                     if (cnt_ff == dlen - 3'd1) begin
                        phase_in     = PH_HEAD;
                        cnt_in       = '0;
                        cmd_valid_in = 1'b1;
                        cmd_in.op    = OP_ENTRY;
                        cmd_in.delta = delta_in;
                        cmd_in.value = value_ff;
                        cmd_tbl_in   = vsel_ff;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   // table data joins the command on its way into the queue
   always_comb begin
      push_cmd = cmd_ff;
      if (cmd_tbl_ff) begin
         push_cmd.value = rd_oor_ff ? '0 : rd_ff;
      end
   end

   assign push_valid = cmd_valid_ff;

endmodule

### rtl/core/spd_queue.sv
// short command queue between the front end and the back end
`include "assert_macros.svh"

module spd_queue
   import spd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    push_ready,
   output logic    pop_valid,
   output cmd_type pop_cmd,
   input  logic    pop_ready
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   cmd_type               entries_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  push;
   logic                  pop;

   assign push_ready = (count_ff != CNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_cmd    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `SPD_ASSERT_IMP(a_count_max, 1'b1, count_ff <= CNT_BITS'(QUEUE_DEPTH))
   `SPD_ASSERT_NXT(a_count_inc, push && !pop, count_ff == $past(count_ff) + CNT_BITS'(1))
   `SPD_ASSERT_NXT(a_count_dec, pop && !push, count_ff == $past(count_ff) - CNT_BITS'(1))

endmodule

### rtl/core/spd_back.sv
// back end: applies commands to the row and column and holds the result register
`include "assert_macros.svh"

module spd_back
   import spd_pkg::*;
#(
   parameter int COORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  cmd_type     in_cmd,
   output logic        in_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_row,
   output logic [31:0] rsp_col,
   output logic [63:0] rsp_value_bits,
   output logic        rsp_group_end
);

   logic [COORD_BITS-1:0] row_ff, row_in;
   logic [COORD_BITS-1:0] col_ff, col_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           row_out_ff, row_out_in;
   logic [31:0]           col_out_ff, col_out_in;
   logic [63:0]           value_out_ff, value_out_in;
   logic                  gend_out_ff, gend_out_in;

   logic                  take;
   logic                  take_clear;
   logic                  take_group;
   logic [4:0]            nib;
   logic [COORD_BITS-1:0] delta_hi;

   assign in_ready   = !rsp_valid_ff || rsp_ready;
   assign take       = in_valid && in_ready;
   assign take_clear = take && (in_cmd.op == OP_CLEAR);
   assign take_group = take && (in_cmd.op == OP_GROUP);
   assign nib        = {1'b0, in_cmd.delta[3:0]} + {1'b0, row_ff[3:0]};
   assign delta_hi   = COORD_BITS'(64'(in_cmd.delta[DELTA_BITS-1:4]));

   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      row_out_in   = row_out_ff;
      col_out_in   = col_out_ff;
      value_out_in = value_out_ff;
      gend_out_in  = gend_out_ff;
      if (take) begin
         case (in_cmd.op)
            OP_ENTRY: begin
               row_in = {row_ff[COORD_BITS-1:4], nib[3:0]};
               col_in = col_ff + COORD_BITS'(nib[4]) + delta_hi;
            end
            OP_GROUP: begin
               row_in = {row_ff[COORD_BITS-1:4] + (COORD_BITS-4)'(1), 4'b0000};
               col_in = '0;
            end
            OP_CLEAR: begin
               row_in = '0;
               col_in = '0;
            end
            default: ;
         endcase
         if (in_cmd.op != OP_CLEAR) begin
            rsp_valid_in = 1'b1;
            row_out_in   = 32'(64'(row_in));
            col_out_in   = 32'(64'(col_in));
            value_out_in = (in_cmd.op == OP_GROUP) ? '0 : in_cmd.value;
            gend_out_in  = (in_cmd.op == OP_GROUP);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_out_ff   <= row_out_in;
      col_out_ff   <= col_out_in;
      value_out_ff <= value_out_in;
      gend_out_ff  <= gend_out_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row        = row_out_ff;
   assign rsp_col        = col_out_ff;
   assign rsp_value_bits = value_out_ff;
   assign rsp_group_end  = gend_out_ff;

   `SPD_ASSERT_NXT(a_clear_zeroes, take_clear, (row_ff == '0) && (col_ff == '0))
   `SPD_ASSERT_NXT(a_group_aligns, take_group, (row_ff[3:0] == 4'd0) && (col_ff == '0))
   `SPD_ASSERT_NXT(a_group_flag, take_group, rsp_group_end)

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench of the sparse packet decoder: directed rows, then random items
module testbench;
   import spd_pkg::*;

   localparam int RANDOM_ITEMS = 500;
   localparam int PAUSE_AT     = 250;
   localparam int STUCK_LIMIT  = 1000;
   localparam int TAIL_CYCLES  = 8;
   // delta byte count per header, four bits per header, header 0 lowest
   localparam logic [31:0] DELTA_BYTES = {4'd5, 4'd2, 4'd0, 4'd5, 4'd3, 4'd1, 4'd0, 4'd0};

   typedef struct packed {
      logic [31:0] row;
      logic [31:0] col;
      logic [63:0] value_bits;
      logic        group_end;
   } decoded_entry_type;

   typedef struct {
      kind_type          kind;
      logic [7:0]        data;
      logic [7:0]        index;
      logic [63:0]       value;
      bit                typed;
      decoded_entry_type want;
   } directed_row_type;

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [1:0]  req_kind        = KIND_BYTE;
   logic [7:0]  req_stream_byte = 8'h00;
   logic [7:0]  req_table_index = 8'h00;
   logic [63:0] req_table_value = 64'h0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [31:0] rsp_row;
   logic [31:0] rsp_col;
   logic [63:0] rsp_value_bits;
   logic        rsp_group_end;

   // decoder state as predicted
   logic [63:0] value_table [256];
   bit          entry_written [256];
   logic [7:0]  written_list [$];
   phase_type   parse_phase = PH_HEAD;
   logic [2:0]  pkt_hdr     = 3'd0;
   logic [3:0]  byte_cnt    = 4'd0;
   logic [44:0] delta_acc   = 45'd0;
   logic [63:0] value_acc   = 64'd0;
   logic [31:0] row_pos     = 32'd0;
   logic [31:0] col_pos     = 32'd0;

   decoded_entry_type pending_entries [$];
   directed_row_type  directed_rows [$];
   decoded_entry_type want;
   bit             idling = 1'b1;
   int             fail_count   = 0;
   int             stuck_cycles = 0;
   int             stall_left   = 0;
   int             stall;

   sparse_packet_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_stream_byte (req_stream_byte),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_row         (rsp_row),
      .rsp_col         (rsp_col),
      .rsp_value_bits  (rsp_value_bits),
      .rsp_group_end   (rsp_group_end)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic decode_item(input kind_type k, input logic [7:0] b, input logic [7:0] idx,
                              input logic [63:0] val, output bit produced,
                              output decoded_entry_type res);
      logic [4:0] nib;
      logic [3:0] dlen;
      bit         payload_done;
      bit         entry_done;
      produced     = 1'b0;
      res          = '0;
      payload_done = 1'b0;
      entry_done   = 1'b0;
      dlen         = DELTA_BYTES[pkt_hdr*4 +: 4];
      case (k)
         KIND_TABLE: begin
            value_table[idx] = val;
            if (!entry_written[idx]) begin
               entry_written[idx] = 1'b1;
               written_list.push_back(idx);
            end
         end
         KIND_CLEAR: begin
            parse_phase = PH_HEAD;
            pkt_hdr     = 3'd0;
            byte_cnt    = 4'd0;
            delta_acc   = 45'd0;
            value_acc   = 64'd0;
            row_pos     = 32'd0;
            col_pos     = 32'd0;
         end
         KIND_BYTE: begin
            case (parse_phase)
               PH_HEAD: begin
                  pkt_hdr   = b[2:0];
                  delta_acc = {40'd0, b[7:3]};
                  value_acc = 64'd0;
                  byte_cnt  = 4'd0;
                  if (pkt_hdr == HDR_GROUP) begin
                     col_pos  = 32'd0;
                     row_pos  = (row_pos + 32'h10) & ~32'hF;
                     produced = 1'b1;
                     res      = {row_pos, col_pos, 64'd0, 1'b1};
                  end else begin
                     parse_phase = (pkt_hdr < HDR_LITERAL_FIRST) ? PH_CODE : PH_VALUE;
                  end
               end
               PH_CODE: begin
                  value_acc    = value_table[b];
                  payload_done = 1'b1;
               end
               PH_VALUE: begin
                  value_acc = value_acc | (64'(b) << (8 * byte_cnt[2:0]));
                  byte_cnt  = byte_cnt + 4'd1;
                  if (byte_cnt >= 4'd8) payload_done = 1'b1;
               end
               default: begin
                  delta_acc = delta_acc | (45'(b) << (5 + 8 * byte_cnt[2:0]));
                  byte_cnt  = byte_cnt + 4'd1;
                  if (byte_cnt >= dlen) entry_done = 1'b1;
               end
            endcase
            if (payload_done) begin
               if (dlen == 4'd0) begin
                  entry_done = 1'b1;
               end else begin
                  parse_phase = PH_DELTA;
                  byte_cnt    = 4'd0;
               end
            end
            if (entry_done) begin
               nib = {1'b0, delta_acc[3:0]} + {1'b0, row_pos[3:0]};
               if (nib[4]) col_pos = col_pos + 32'd1;
               row_pos     = {row_pos[31:4], nib[3:0]};
               col_pos     = col_pos + 32'(delta_acc >> 4);
               produced    = 1'b1;
               res         = {row_pos, col_pos, value_acc, 1'b0};
               parse_phase = PH_HEAD;
               byte_cnt    = 4'd0;
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic drive_item(input kind_type k, input logic [7:0] data, input logic [7:0] index,
                             input logic [63:0] value, input bit typed,
                             input decoded_entry_type typed_want);
      int                gap;
      bit                produced;
      decoded_entry_type res;
      gap = idling ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= k;
      req_stream_byte <= data;
      req_table_index <= index;
      req_table_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_item(k, data, index, value, produced, res);
      if (produced) pending_entries.push_back(typed ? typed_want : res);
   endtask

   task automatic add_row(input kind_type k, input logic [7:0] data, input logic [7:0] index,
                          input logic [63:0] value, input bit typed,
                          input decoded_entry_type typed_want);
      directed_row_type r;
      r.kind  = k;
      r.data  = data;
      r.index = index;
      r.value = value;
      r.typed = typed;
      r.want  = typed_want;
      directed_rows.push_back(r);
   endtask

   function automatic logic [7:0] random_byte();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'hFF;
      return 8'($urandom);
   endfunction

   // result side: check every item against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b1;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_entries.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected item: row %h col %h value %h group_end %b",
                           rsp_row, rsp_col, rsp_value_bits, rsp_group_end);
               fail_count++;
            end else begin
               want = pending_entries.pop_front();
               if (rsp_row !== want.row || rsp_col !== want.col ||
                   rsp_value_bits !== want.value_bits || rsp_group_end !== want.group_end) begin
                  if (fail_count < 10)
                     $display("mismatch (exp/got): row %h/%h col %h/%h value %h/%h group_end %b/%b",
                              want.row, rsp_row, want.col, rsp_col, want.value_bits,
                              rsp_value_bits, want.group_end, rsp_group_end);
                  fail_count++;
               end
            end
            stall = idling ? $urandom_range(0, 4) : 0;
            rsp_ready  <= (stall == 0);
            stall_left <= stall;
         end else if (stall_left != 0) begin
            if (stall_left == 1) rsp_ready <= 1'b1;
            stall_left <= stall_left - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
   end

   initial begin
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int                random_sent;
      int                pick;
      logic [7:0]        data;
      directed_row_type  r;
      add_row(KIND_UNUSED, 8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0);
      add_row(KIND_BYTE, 8'h00, 8'h00, 64'h0, 1'b1, {32'h10, 32'h0, 64'h0, 1'b1});
      add_row(KIND_TABLE, 8'h00, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0);
      add_row(KIND_BYTE, 8'hF9, 8'h00, 64'h0, 1'b0, '0);
      add_row(KIND_BYTE, 8'hFF, 8'h00, 64'h0, 1'b1,
              {32'h1F, 32'h1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0});
      // table written inside a packet, before and after its code byte
      add_row(KIND_BYTE, 8'hFC, 8'h00, 64'h0, 1'b0, '0);
      add_row(KIND_TABLE, 8'h00, 8'h00, 64'h0123_4567_89AB_CDEF, 1'b0, '0);
      add_row(KIND_BYTE, 8'h00, 8'h00, 64'h0, 1'b0, '0);
      add_row(KIND_TABLE, 8'h00, 8'h00, 64'h0, 1'b0, '0);
      for (int i = 0; i < 5; i++) add_row(KIND_BYTE, 8'hFF, 8'h00, 64'h0, 1'b0, '0);
      add_row(KIND_BYTE, 8'hFD, 8'h00, 64'h0, 1'b0, '0);
      for (int i = 0; i < 8; i++) add_row(KIND_BYTE, 8'hFF, 8'h00, 64'h0, 1'b0, '0);
      add_row(KIND_CLEAR, 8'h00, 8'h00, 64'h0, 1'b0, '0);
      add_row(KIND_BYTE, 8'h00, 8'h00, 64'h0, 1'b1, {32'h10, 32'h0, 64'h0, 1'b1});

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         drive_item(r.kind, r.data, r.index, r.value, r.typed, r.want);
      end

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent % 40 == 0) idling = ($urandom_range(0, 3) != 0);
         if (random_sent == PAUSE_AT) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_entries.size() != 0) @(posedge clock);
         end
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            drive_item(KIND_TABLE, random_byte(), 8'($urandom), {$urandom, $urandom}, 1'b0, '0);
            random_sent++;
         end else if (pick < 9) begin
            drive_item(KIND_UNUSED, random_byte(), 8'($urandom), {$urandom, $urandom}, 1'b0, '0);
         end else if (pick < 11) begin
            drive_item(KIND_CLEAR, random_byte(), 8'($urandom), {$urandom, $urandom}, 1'b0, '0);
            random_sent++;
         end else begin
            // code bytes only select entries already written
            if (parse_phase == PH_CODE)
               data = written_list[$urandom_range(0, written_list.size() - 1)];
            else
               data = random_byte();
            drive_item(KIND_BYTE, data, 8'($urandom), {$urandom, $urandom}, 1'b0, '0);
            random_sent++;
         end
      end
      req_valid <= 1'b0;

      while (pending_entries.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

### files.f
+incdir+rtl/core
rtl/core/spd_pkg.sv
rtl/core/spd_front.sv
rtl/core/spd_queue.sv
rtl/core/spd_back.sv
rtl/core/sparse_packet_decoder.sv
tb/testbench.sv
